// ----- hdl/multiturn_encoder_tracker_macros.svh -----
// Assertion macros shared by the encoder tracker checker.
`ifndef MULTITURN_ENCODER_TRACKER_MACROS_SVH
`define MULTITURN_ENCODER_TRACKER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define MTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("encoder tracker check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define MTT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("encoder tracker check failed");

`endif

// ----- hdl/mtt_pkg.sv -----
// Shared types and constants of the multi-turn encoder tracker.
package mtt_pkg;

  localparam int EncoderCounts = 8192;
  localparam int EncW          = 13;
  localparam int MotorCount    = 2;
  localparam int MotorW        = 1;
  localparam int SpeedW        = 16;
  localparam int TurnW         = 16;
  localparam int PosW          = 30;
  localparam int TurnPad       = PosW - TurnW - EncW;
  localparam int DeltaW        = 14;
  localparam int VelW          = 15;
  localparam int GainW         = 16;
  localparam int CalibW        = 6;
  localparam int CfgDataW      = 16;
  localparam int CfgAddrW      = 1;
  localparam int QueueDepth    = 2;

  localparam int DefWindowLen  = 30;
  localparam int DefSumLen     = 28;

  localparam logic [CalibW-1:0] CalibCountReset   = 6'd50;
  localparam logic [GainW-1:0]  VelocityGainReset = 16'd5356;

  localparam int InDataW   = 32;
  localparam int InUserW   = 1;
  localparam int OutDataW  = 80;
  localparam int OutUserW  = 2;
  localparam int OutPad    = OutDataW - (SpeedW + TurnW + PosW + VelW);

  typedef enum logic [CfgAddrW-1:0] {
    CfgCalibCount   = 1'b0,
    CfgVelocityGain = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [MotorW-1:0] motor;
    logic              cal;
    logic [EncW-1:0]   pos;
    logic [SpeedW-1:0] speed;
  } item_t;

endpackage

// ----- hdl/multiturn_encoder_tracker.sv -----
// Top level of the two-motor multi-turn encoder tracker.
// Each accepted sample yields one result, in order. A calibration sample passes
// through the sequencer states SCalc and SEmit, and a tracking sample through
// SCalc, SPos, SStore and SEmit; the sample that closes a velocity window adds
// SSum, SMul and SScale: the sum of min(SumLen, WindowLen) entries runs through the
// delta memory one entry per cycle on its single read port, then a multiply and a
// scale step. A two-entry queue lets the input keep taking samples while the
// sequencer works or while a result waits on the output register, until it is full.
module multiturn_encoder_tracker #(
  parameter int WindowLen = mtt_pkg::DefWindowLen,
  parameter int SumLen    = mtt_pkg::DefSumLen
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mtt_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [mtt_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // encoder_pos [12:0], speed_raw [28:13], zero [31:29]
  input  logic [mtt_pkg::InDataW-1:0]   s_axis_tdata_i,
  // motor_sel [0]
  input  logic [mtt_pkg::InUserW-1:0]   s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // speed [15:0], turns [31:16], position [61:32], velocity [76:62], zero [79:77]
  output logic [mtt_pkg::OutDataW-1:0]  m_axis_tdata_o,
  // out_motor [0], calibrating [1]
  output logic [mtt_pkg::OutUserW-1:0]  m_axis_tuser_o
);
  import mtt_pkg::*;

  logic [CalibW-1:0] calib_count_q;
  logic [GainW-1:0]  gain_q;
  logic              push;
  item_t             push_data;
  logic              full;
  logic              pop;
  item_t             head;
  logic              empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      calib_count_q <= CalibCountReset;
      gain_q        <= VelocityGainReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CfgCalibCount:   calib_count_q <= cfg_data_i[CalibW-1:0];
        CfgVelocityGain: gain_q        <= cfg_data_i[GainW-1:0];
        default: ;
      endcase
    end
  end

  mtt_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .calib_count_i   (calib_count_q),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .push_o          (push),
    .push_data_o     (push_data),
    .full_i          (full)
  );

  mtt_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty)
  );

  mtt_back #(
    .WindowLen (WindowLen),
    .SumLen    (SumLen)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .gain_i          (gain_q),
    .head_i          (head),
    .empty_i         (empty),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ----- hdl/mtt_fifo.sv -----
// Two-entry queue between the sample classifier and the tracking sequencer.
module mtt_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mtt_pkg::item_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output mtt_pkg::item_t head_o,
  output logic          empty_o
);
  import mtt_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  item_t           entry_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- hdl/mtt_front.sv -----
// Input side: accepts samples and marks the ones used for offset capture.
module mtt_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [mtt_pkg::CalibW-1:0]   calib_count_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [mtt_pkg::InDataW-1:0]  s_axis_tdata_i,
  input  logic [mtt_pkg::InUserW-1:0]  s_axis_tuser_i,
  output logic                         push_o,
  output mtt_pkg::item_t               push_data_o,
  input  logic                         full_i
);
  import mtt_pkg::*;

  localparam logic [CalibW-1:0] CountMax = '1;

  logic [CalibW-1:0] sample_cnt_q [MotorCount];
  logic [MotorW-1:0] motor;
  logic              motor_ok;
  logic              accept;
  logic [CalibW-1:0] cur_cnt;

  assign motor    = s_axis_tuser_i[MotorW-1:0];
  assign motor_ok = (int'(motor) < MotorCount);
  assign cur_cnt  = sample_cnt_q[motor];

  assign s_axis_tready_o = !full_i;
  assign accept          = s_axis_tvalid_i && !full_i;
  // A sample for a motor that does not exist is taken and dropped.
  assign push_o          = accept && motor_ok;

  always_comb begin
    push_data_o.motor = motor;
    push_data_o.cal   = (cur_cnt < calib_count_i);
    push_data_o.pos   = s_axis_tdata_i[EncW-1:0];
    push_data_o.speed = s_axis_tdata_i[EncW+SpeedW-1:EncW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MotorCount; i++) begin
        sample_cnt_q[i] <= '0;
      end
    end else if (push_o && (cur_cnt != CountMax)) begin
      sample_cnt_q[motor] <= cur_cnt + 1'b1;
    end
  end

endmodule

// ----- hdl/mtt_back.sv -----
// Tracking sequencer: turn counting, position, delta window and velocity.
module mtt_back #(
  parameter int WindowLen = mtt_pkg::DefWindowLen,
  parameter int SumLen    = mtt_pkg::DefSumLen
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mtt_pkg::GainW-1:0]     gain_i,
  input  mtt_pkg::item_t                head_i,
  input  logic                          empty_i,
  output logic                          pop_o,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [mtt_pkg::OutDataW-1:0]  m_axis_tdata_o,
  output logic [mtt_pkg::OutUserW-1:0]  m_axis_tuser_o
);
  import mtt_pkg::*;

  localparam int NSum  = (SumLen < WindowLen) ? SumLen : WindowLen;
  localparam int Depth = MotorCount * WindowLen;
  localparam int AddrW = $clog2(Depth);
  localparam int IdxW  = $clog2(WindowLen);
  localparam int CntW  = $clog2(NSum + 1);
  localparam int SumW  = DeltaW + $clog2(NSum + 1);
  localparam int ProdW = SumW + GainW + 1;
  localparam int ShW   = ProdW - 16;

  localparam logic signed [EncW:0]  HalfRev  = (EncW+1)'(EncoderCounts / 2);
  localparam logic signed [PosW:0]  DeltaHi  = (PosW+1)'(2**(DeltaW-1) - 1);
  localparam logic signed [PosW:0]  DeltaLo  = (PosW+1)'(-(2**(DeltaW-1)));
  localparam logic signed [ShW-1:0] VelHi    = ShW'(2**(VelW-1) - 1);
  localparam logic signed [ShW-1:0] VelLo    = ShW'(-(2**(VelW-1)));
  localparam logic signed [ProdW-1:0] RoundBias = ProdW'(65535);

  typedef enum logic [7:0] {
    SIdle  = 8'b0000_0001,
    SCalc  = 8'b0000_0010,
    SPos   = 8'b0000_0100,
    SStore = 8'b0000_1000,
    SSum   = 8'b0001_0000,
    SMul   = 8'b0010_0000,
    SScale = 8'b0100_0000,
    SEmit  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  item_t  item_q;

  logic [EncW-1:0]  prev_enc_q  [MotorCount];
  logic [TurnW-1:0] turns_q     [MotorCount];
  logic [EncW-1:0]  offset_q    [MotorCount];
  logic [PosW-1:0]  prev_pos_q  [MotorCount];
  logic [IdxW-1:0]  widx_q      [MotorCount];
  logic [VelW-1:0]  vel_q       [MotorCount];

  logic [DeltaW-1:0]        delta_mem_q [Depth];
  logic signed [DeltaW-1:0] rdata_q;
  logic signed [DeltaW-1:0] delta_q;
  logic [PosW-1:0]          position_q;
  logic [AddrW-1:0]         base_q;
  logic [CntW-1:0]          rd_cnt_q;
  logic                     rd_vld_q;
  logic signed [SumW-1:0]   acc_q;
  logic signed [ProdW-1:0]  prod_q;

  logic                     out_valid_q;
  logic [OutDataW-1:0]      out_data_q;
  logic [OutUserW-1:0]      out_user_q;

  logic [MotorW-1:0]        m;
  logic signed [EncW:0]     diff;
  logic [TurnW-1:0]         turns_next;
  logic [PosW-1:0]          turn_part;
  logic [PosW-1:0]          position_d;
  logic signed [PosW:0]     delta_full;
  logic signed [DeltaW-1:0] delta_sat;
  logic [AddrW-1:0]         wr_addr;
  logic [AddrW-1:0]         rd_addr;
  logic                     window_end;
  logic                     rd_en;
  logic                     sum_done;
  logic                     load_out;
  logic signed [ProdW-1:0]  biased;
  logic signed [ShW-1:0]    shifted;
  logic [VelW-1:0]          vel_sat;

  assign m = item_q.motor;

  always_comb begin
    diff = signed'({1'b0, item_q.pos}) - signed'({1'b0, prev_enc_q[m]});
    turns_next = turns_q[m];
    // A jump forward of more than half a turn means the shaft wrapped backward.
    if (diff > HalfRev) begin
      turns_next = turns_q[m] - 1'b1;
    end else if (diff < -HalfRev) begin
      turns_next = turns_q[m] + 1'b1;
    end
  end

  always_comb begin
    turn_part  = {{TurnPad{turns_q[m][TurnW-1]}}, turns_q[m], {EncW{1'b0}}};
    position_d = turn_part + PosW'(item_q.pos) - PosW'(offset_q[m]);
    delta_full = signed'({position_d[PosW-1], position_d})
               - signed'({prev_pos_q[m][PosW-1], prev_pos_q[m]});
    if (delta_full > DeltaHi) begin
      delta_sat = DeltaW'(DeltaHi);
    end else if (delta_full < DeltaLo) begin
      delta_sat = DeltaW'(DeltaLo);
    end else begin
      delta_sat = DeltaW'(delta_full);
    end
  end

  assign wr_addr    = AddrW'(AddrW'(m) * AddrW'(WindowLen)) + AddrW'(widx_q[m]);
  assign rd_addr    = base_q + AddrW'(rd_cnt_q);
  assign window_end = (widx_q[m] == IdxW'(WindowLen - 1));
  assign rd_en      = (state_q == SSum) && (rd_cnt_q != CntW'(NSum));
  assign sum_done   = (rd_cnt_q == CntW'(NSum)) && !rd_vld_q;

  // Truncate toward zero: negative products take a bias before the shift.
  always_comb begin
    biased  = prod_q + (prod_q[ProdW-1] ? RoundBias : '0);
    shifted = ShW'(biased >>> 16);
    if (shifted > VelHi) begin
      vel_sat = VelW'(VelHi);
    end else if (shifted < VelLo) begin
      vel_sat = VelW'(VelLo);
    end else begin
      vel_sat = VelW'(shifted);
    end
  end

  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = SCalc;
        end
      end
      SCalc:  state_d = item_q.cal ? SEmit : SPos;
      SPos:   state_d = SStore;
      SStore: state_d = window_end ? SSum : SEmit;
      SSum: begin
        if (sum_done) begin
          state_d = SMul;
        end
      end
      SMul:   state_d = SScale;
      SScale: state_d = SEmit;
      SEmit: begin
        if (!out_valid_q || m_axis_tready_i) begin
          load_out = 1'b1;
          state_d  = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      out_valid_q <= 1'b0;
      rd_cnt_q    <= '0;
      rd_vld_q    <= 1'b0;
      for (int i = 0; i < MotorCount; i++) begin
        prev_enc_q[i] <= '0;
        turns_q[i]    <= '0;
        offset_q[i]   <= '0;
        prev_pos_q[i] <= '0;
        widx_q[i]     <= '0;
        vel_q[i]      <= '0;
      end
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == SCalc) begin
        prev_enc_q[m] <= item_q.pos;
        if (item_q.cal) begin
          offset_q[m]   <= item_q.pos;
          prev_pos_q[m] <= '0;
        end else begin
          turns_q[m] <= turns_next;
        end
      end
      if (state_q == SPos) begin
        prev_pos_q[m] <= position_d;
      end
      if (state_q == SStore) begin
        rd_cnt_q  <= '0;
        widx_q[m] <= window_end ? '0 : widx_q[m] + 1'b1;
      end
      if (rd_en) begin
        rd_cnt_q <= rd_cnt_q + 1'b1;
      end
      if (state_q == SScale) begin
        vel_q[m] <= vel_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      item_q <= head_i;
    end
    if (state_q == SCalc) begin
      position_q <= '0;
    end
    if (state_q == SPos) begin
      position_q <= position_d;
      delta_q    <= delta_sat;
    end
    if (state_q == SStore) begin
      base_q <= AddrW'(AddrW'(m) * AddrW'(WindowLen));
      acc_q  <= '0;
    end else if (rd_vld_q) begin
      acc_q <= acc_q + SumW'(rdata_q);
    end
    if (state_q == SMul) begin
      prod_q <= acc_q * signed'({1'b0, gain_i});
    end
    if (load_out) begin
      out_data_q <= {{OutPad{1'b0}}, vel_q[m], position_q, turns_q[m], item_q.speed};
      out_user_q <= {item_q.cal, m};
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SStore) begin
      delta_mem_q[wr_addr] <= delta_q;
    end
    if (rd_en) begin
      rdata_q <= delta_mem_q[rd_addr];
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ----- hdl/mtt_checker.sv -----
// Port-level checks of the encoder tracker and their binding to the top level.
`include "multiturn_encoder_tracker_macros.svh"

module mtt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [mtt_pkg::OutDataW-1:0]  m_axis_tdata_o,
  input logic [mtt_pkg::OutUserW-1:0]  m_axis_tuser_o
);
  import mtt_pkg::*;

  logic                         out_stall;
  logic [OutUserW+OutDataW-1:0] out_word;

  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_word  = {m_axis_tuser_o, m_axis_tdata_o};

  // A stalled result transaction keeps its payload.
  `MTT_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid_o && $stable(out_word))

  // A calibration sample always reports a zero position.
  `MTT_ASSERT_IMP(a_cal_pos_zero, m_axis_tvalid_o && m_axis_tuser_o[1], m_axis_tdata_o[61:32] == '0)

  // The padding above the velocity field stays clear.
  `MTT_ASSERT_IMP(a_out_pad_zero, m_axis_tvalid_o, m_axis_tdata_o[79:77] == '0)

endmodule

bind multiturn_encoder_tracker mtt_checker u_checker (.*);
